// ===== rtl/tle_pkg.sv =====
// Shared constants, types and the echo string table for the telnet line editor.
// No dependencies.
package tle_pkg;

  localparam int LINE_MAX = 32;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int CNT_W    = 6;
  localparam int PTR_W    = 5;

  localparam logic [2:0] MODE_READY = 3'd0;
  localparam logic [2:0] MODE_IAC   = 3'd1;
  localparam logic [2:0] MODE_VERB  = 3'd2;
  localparam logic [2:0] MODE_ESC   = 3'd3;
  localparam logic [2:0] MODE_CSI   = 3'd4;

  localparam logic [1:0] DEST_ECHO = 2'd0;
  localparam logic [1:0] DEST_LINE = 2'd1;
  localparam logic [1:0] DEST_EOL  = 2'd2;
  localparam logic [1:0] DEST_INTR = 2'd3;

  localparam logic [7:0] CH_IAC   = 8'hFF;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // string table offsets
  localparam logic [PTR_W-1:0] STR_CLR_B  = 5'd0;   // ESC[1000D ESC[0K
  localparam logic [PTR_W-1:0] STR_CLR_E  = 5'd10;
  localparam logic [PTR_W-1:0] STR_HOME_B = 5'd11;  // ESC[1000D
  localparam logic [PTR_W-1:0] STR_HOME_E = 5'd17;
  localparam logic [PTR_W-1:0] STR_CSI_B  = 5'd18;  // ESC[
  localparam logic [PTR_W-1:0] STR_CSI_E  = 5'd19;
  localparam logic [PTR_W-1:0] STR_BSB_B  = 5'd20;  // BS SP BS
  localparam logic [PTR_W-1:0] STR_BSB_E  = 5'd22;
  localparam logic [PTR_W-1:0] STR_LEFT_B = 5'd23;  // ESC[D
  localparam logic [PTR_W-1:0] STR_LEFT_E = 5'd25;
  localparam logic [PTR_W-1:0] STR_CRLF_B = 5'd26;
  localparam logic [PTR_W-1:0] STR_CRLF_E = 5'd27;

  typedef struct packed {
    logic       valid;
    logic [1:0] dest;
    logic [7:0] data;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] cur;
  } status_t;

  function automatic logic [7:0] str_byte(input logic [PTR_W-1:0] p);
    logic [7:0] r;
    case (p)
      5'd0, 5'd7, 5'd11, 5'd18, 5'd23: r = 8'h1B;
      5'd1, 5'd8, 5'd12, 5'd19, 5'd24: r = 8'h5B;
      5'd2, 5'd13:                     r = 8'h31;
      5'd3, 5'd4, 5'd5, 5'd9,
      5'd14, 5'd15, 5'd16:             r = 8'h30;
      5'd6, 5'd17, 5'd25:              r = 8'h44;
      5'd10:                           r = 8'h4B;
      5'd20, 5'd22:                    r = 8'h08;
      5'd21:                           r = 8'h20;
      5'd26:                           r = 8'h0D;
      5'd27:                           r = 8'h0A;
      default:                         r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] dec_tens(input logic [CNT_W-1:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

endpackage

// ===== rtl/tle_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
// No dependencies.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tle_obuf.sv =====
// Output register between the sequencer and the result channel.
// Depends on tle_pkg.
module tle_obuf (
  input  logic          clk,
  input  logic          rst,
  input  tle_pkg::emit_t emit,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    dest,
  output logic [7:0]    out_data,
  output logic          last
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= emit.valid;
    end
    if (free && emit.valid) begin
      dest     <= emit.dest;
      out_data <= emit.data;
      last     <= emit.last;
    end
  end

endmodule

// ===== rtl/tle_seq.sv =====
// Parser and edit sequencer: read-modify-write of the line store, echo and line emission.
// Depends on tle_pkg; drives the ports of a tle_ram instance.
module tle_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_stall,
  input  logic [7:0]                 rx_byte,
  input  logic                       free,
  output tle_pkg::emit_t             emit,
  output tle_pkg::status_t           status,
  output logic                       ram_we,
  output logic [tle_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata,
  output logic                       ram_re,
  output logic [tle_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SHR_RD = 4'd1;
  localparam logic [3:0] S_SHR_WR = 4'd2;
  localparam logic [3:0] S_SHL_RD = 4'd3;
  localparam logic [3:0] S_SHL_WR = 4'd4;
  localparam logic [3:0] S_STR    = 4'd5;
  localparam logic [3:0] S_LRD    = 4'd6;
  localparam logic [3:0] S_LEM    = 4'd7;
  localparam logic [3:0] S_MARK   = 4'd8;
  localparam logic [3:0] S_TENS   = 4'd9;
  localparam logic [3:0] S_ONES   = 4'd10;
  localparam logic [3:0] S_CEND   = 4'd11;
  localparam logic [3:0] S_ECHO   = 4'd12;
  localparam logic [3:0] S_POS    = 4'd13;

  localparam logic [tle_pkg::CNT_W-1:0] LMAX = tle_pkg::CNT_W'(tle_pkg::LINE_MAX);
  localparam logic [tle_pkg::CNT_W-1:0] ONE  = tle_pkg::CNT_W'(1);
  localparam logic [tle_pkg::CNT_W-1:0] TEN  = tle_pkg::CNT_W'(10);

  logic [3:0]                       state, state_next;
  logic [2:0]                       mode, mode_next;
  logic [tle_pkg::CNT_W-1:0]        len, len_next, cur, cur_next, idx, idx_next;
  logic [tle_pkg::PTR_W-1:0]        ptr, ptr_next, str_end, str_end_next;
  logic [3:0]                       str_after, str_after_next;
  logic                             job_cr, job_cr_next;
  logic [7:0]                       byte_r, byte_r_next;
  logic [1:0]                       edest, edest_next;
  logic [2:0]                       tens;
  logic [tle_pkg::CNT_W-1:0]        ones;

  assign rx_stall = (state != S_IDLE);
  assign status   = '{len: len, cur: cur};
  assign tens     = tle_pkg::dec_tens(cur);
  assign ones     = cur - (tle_pkg::CNT_W'(tens) * TEN);

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    len_next       = len;
    cur_next       = cur;
    idx_next       = idx;
    ptr_next       = ptr;
    str_end_next   = str_end;
    str_after_next = str_after;
    job_cr_next    = job_cr;
    byte_r_next    = byte_r;
    edest_next     = edest;
    emit           = '0;
    ram_we         = 1'b0;
    ram_waddr      = idx[tle_pkg::ADDR_W-1:0];
    ram_wdata      = byte_r;
    ram_re         = 1'b0;
    ram_raddr      = idx[tle_pkg::ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (rx_valid) begin
          case (mode)
            tle_pkg::MODE_READY: begin
              case (rx_byte)
                tle_pkg::CH_IAC: mode_next = tle_pkg::MODE_IAC;
                tle_pkg::CH_ESC: mode_next = tle_pkg::MODE_ESC;
                tle_pkg::CH_ETX: begin
                  edest_next  = tle_pkg::DEST_INTR;
                  byte_r_next = tle_pkg::CH_ETX;
                  state_next  = S_ECHO;
                end
                tle_pkg::CH_LF: ;
                tle_pkg::CH_CR: begin
                  idx_next    = '0;
                  job_cr_next = 1'b1;
                  state_next  = S_LRD;
                end
                tle_pkg::CH_DEL: begin
                  if (len != '0 && cur != '0) begin
                    cur_next   = cur - ONE;
                    idx_next   = cur - ONE;
                    state_next = S_SHL_RD;
                  end
                end
                default: begin
                  if (len < LMAX) begin
                    if (cur == len) begin
                      ram_we      = 1'b1;
                      ram_waddr   = len[tle_pkg::ADDR_W-1:0];
                      ram_wdata   = rx_byte;
                      len_next    = len + ONE;
                      cur_next    = cur + ONE;
                      edest_next  = tle_pkg::DEST_ECHO;
                      byte_r_next = rx_byte;
                      state_next  = S_ECHO;
                    end else begin
                      byte_r_next = rx_byte;
                      idx_next    = len;
                      state_next  = S_SHR_RD;
                    end
                  end
                end
              endcase
            end
            tle_pkg::MODE_IAC: begin
              if (rx_byte == tle_pkg::CH_IAC) begin
                if (len < LMAX) begin
                  ram_we    = 1'b1;
                  ram_waddr = len[tle_pkg::ADDR_W-1:0];
                  ram_wdata = tle_pkg::CH_IAC;
                  len_next  = len + ONE;
                end
                mode_next = tle_pkg::MODE_READY;
              end else begin
                mode_next = tle_pkg::MODE_VERB;
              end
            end
            tle_pkg::MODE_ESC: begin
              mode_next = (rx_byte == tle_pkg::CH_LBRK) ? tle_pkg::MODE_CSI
                                                        : tle_pkg::MODE_READY;
            end
            tle_pkg::MODE_CSI: begin
              if (!(rx_byte inside {[8'h20:8'h2F]})) begin
                if (rx_byte == tle_pkg::CH_D && cur != '0) begin
                  cur_next       = cur - ONE;
                  ptr_next       = tle_pkg::STR_LEFT_B;
                  str_end_next   = tle_pkg::STR_LEFT_E;
                  str_after_next = S_IDLE;
                  state_next     = S_STR;
                end
                mode_next = tle_pkg::MODE_READY;
              end
            end
            default: mode_next = tle_pkg::MODE_READY;
          endcase
        end
      end

      // open a gap at the cursor, top entry first
      S_SHR_RD: begin
        if (idx == cur) begin
          ram_we         = 1'b1;
          ram_waddr      = cur[tle_pkg::ADDR_W-1:0];
          len_next       = len + ONE;
          cur_next       = cur + ONE;
          idx_next       = '0;
          job_cr_next    = 1'b0;
          ptr_next       = tle_pkg::STR_CLR_B;
          str_end_next   = tle_pkg::STR_CLR_E;
          str_after_next = S_LRD;
          state_next     = S_STR;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = idx[tle_pkg::ADDR_W-1:0] - 1'b1;
          state_next = S_SHR_WR;
        end
      end
      S_SHR_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        idx_next   = idx - ONE;
        state_next = S_SHR_RD;
      end

      // close the gap left by the deleted byte
      S_SHL_RD: begin
        if (idx + ONE >= len) begin
          len_next = len - ONE;
          if (cur == len - ONE) begin
            ptr_next       = tle_pkg::STR_BSB_B;
            str_end_next   = tle_pkg::STR_BSB_E;
            str_after_next = S_IDLE;
          end else begin
            idx_next       = '0;
            job_cr_next    = 1'b0;
            ptr_next       = tle_pkg::STR_CLR_B;
            str_end_next   = tle_pkg::STR_CLR_E;
            str_after_next = S_LRD;
          end
          state_next = S_STR;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = idx[tle_pkg::ADDR_W-1:0] + 1'b1;
          state_next = S_SHL_WR;
        end
      end
      S_SHL_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        idx_next   = idx + ONE;
        state_next = S_SHL_RD;
      end

      S_STR: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.dest  = tle_pkg::DEST_ECHO;
          emit.data  = tle_pkg::str_byte(ptr);
          emit.last  = (ptr == str_end) && (str_after == S_IDLE);
          if (ptr == str_end) begin
            state_next = str_after;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
      end

      S_LRD: begin
        if (idx == len) begin
          if (job_cr) begin
            state_next = S_MARK;
          end else begin
            ptr_next       = tle_pkg::STR_HOME_B;
            str_end_next   = tle_pkg::STR_HOME_E;
            str_after_next = (cur != '0) ? S_POS : S_IDLE;
            state_next     = S_STR;
          end
        end else begin
          ram_re     = 1'b1;
          state_next = S_LEM;
        end
      end
      S_LEM: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.dest  = job_cr ? tle_pkg::DEST_LINE : tle_pkg::DEST_ECHO;
          emit.data  = ram_rdata;
          idx_next   = idx + ONE;
          state_next = S_LRD;
        end
      end

      S_MARK: begin
        if (free) begin
          emit.valid     = 1'b1;
          emit.dest      = tle_pkg::DEST_EOL;
          len_next       = '0;
          cur_next       = '0;
          ptr_next       = tle_pkg::STR_CRLF_B;
          str_end_next   = tle_pkg::STR_CRLF_E;
          str_after_next = S_IDLE;
          state_next     = S_STR;
        end
      end

      S_POS: begin
        ptr_next       = tle_pkg::STR_CSI_B;
        str_end_next   = tle_pkg::STR_CSI_E;
        str_after_next = S_TENS;
        state_next     = S_STR;
      end
      S_TENS: begin
        if (tens == '0) begin
          state_next = S_ONES;
        end else if (free) begin
          emit.valid = 1'b1;
          emit.dest  = tle_pkg::DEST_ECHO;
          emit.data  = tle_pkg::CH_ZERO + 8'(tens);
          state_next = S_ONES;
        end
      end
      S_ONES: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.dest  = tle_pkg::DEST_ECHO;
          emit.data  = tle_pkg::CH_ZERO + 8'(ones);
          state_next = S_CEND;
        end
      end
      S_CEND: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.dest  = tle_pkg::DEST_ECHO;
          emit.data  = tle_pkg::CH_C;
          emit.last  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_ECHO: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.dest  = edest;
          emit.data  = byte_r;
          emit.last  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= tle_pkg::MODE_READY;
      len   <= '0;
      cur   <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      len   <= len_next;
      cur   <= cur_next;
    end
    idx       <= idx_next;
    ptr       <= ptr_next;
    str_end   <= str_end_next;
    str_after <= str_after_next;
    job_cr    <= job_cr_next;
    byte_r    <= byte_r_next;
    edest     <= edest_next;
  end

endmodule

// ===== rtl/telnet_line_editor_top.sv =====
// Telnet line editor: line store RAM, edit sequencer and output register.
// A plain echo passes through the sequencer state register and then the output register; a redraw
// reads each stored byte and then emits it, after a shift that reads and then writes each moved byte.
// Input: one byte at a time; rx_stall stays high until the last result is loaded into the
// output register.
// Reset (rst, synchronous): empty line, cursor 0, ready mode; store contents undefined.
module telnet_line_editor_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] dest,
  output logic [7:0] out_data,
  output logic       last
);

  tle_pkg::emit_t             emit;
  tle_pkg::status_t           status;
  logic                       free;
  logic                       ram_we, ram_re;
  logic [tle_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata;

  tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::LINE_MAX)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  tle_seq u_seq (
    .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .free(free), .emit(emit), .status(status),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_re(ram_re), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
  );

  tle_obuf u_obuf (
    .clk(clk), .rst(rst), .emit(emit), .free(free),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest(dest), .out_data(out_data), .last(last)
  );

  a_cur_in_line: assert property (@(posedge clk) disable iff (rst)
    status.cur <= status.len) else $error("cursor beyond line end");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    status.len <= tle_pkg::CNT_W'(tle_pkg::LINE_MAX)) else $error("line length overflow");

  a_no_emit_blocked: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> free) else $error("result produced while output register full");

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && ram_waddr == ram_raddr)) else $error("read and write collide");

endmodule

// ===== test/telnet_line_editor_top_tb.sv =====
// Self-checking testbench for the telnet line editor: a line-state predictor, a queued driver
// with random input gaps and random output stalls, and a monitor. Uses tle_pkg.
module telnet_line_editor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WD_LIMIT = 1000;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] data;
    logic       last;
  } echo_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] dest;
  logic [7:0] out_data;
  logic       last;

  telnet_line_editor_top uut (
    .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .dest(dest), .out_data(out_data),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0] line_buf [tle_pkg::LINE_MAX];
  int         line_len = 0;
  int         cur_pos  = 0;
  logic [2:0] pmode    = tle_pkg::MODE_READY;

  echo_item_t expected_q [$];
  logic [7:0] pending_q [$];
  int         step_n;
  int         mismatches = 0;
  bit         stim_done = 1'b0;
  int         idle_cycles = 0;
  int         tx_gap = 0;
  int         rs_gap = 0;
  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;

  function automatic void add_byte(logic [7:0] b);
    pending_q = {pending_q, b};
  endfunction

  function automatic void put(logic [1:0] d, logic [7:0] v);
    echo_item_t e;
    e.dest = d;
    e.data = v;
    e.last = 1'b0;
    expected_q = {expected_q, e};
    step_n++;
  endfunction

  function automatic void put_home();
    put(tle_pkg::DEST_ECHO, tle_pkg::CH_ESC); put(tle_pkg::DEST_ECHO, tle_pkg::CH_LBRK);
    put(tle_pkg::DEST_ECHO, "1"); put(tle_pkg::DEST_ECHO, "0");
    put(tle_pkg::DEST_ECHO, "0"); put(tle_pkg::DEST_ECHO, "0");
    put(tle_pkg::DEST_ECHO, tle_pkg::CH_D);
  endfunction

  function automatic void put_redraw();
    put_home();
    put(tle_pkg::DEST_ECHO, tle_pkg::CH_ESC); put(tle_pkg::DEST_ECHO, tle_pkg::CH_LBRK);
    put(tle_pkg::DEST_ECHO, "0"); put(tle_pkg::DEST_ECHO, "K");
    for (int i = 0; i < line_len; i++) put(tle_pkg::DEST_ECHO, line_buf[i]);
    put_home();
    if (cur_pos != 0) begin
      put(tle_pkg::DEST_ECHO, tle_pkg::CH_ESC); put(tle_pkg::DEST_ECHO, tle_pkg::CH_LBRK);
      if (cur_pos >= 10) put(tle_pkg::DEST_ECHO, tle_pkg::CH_ZERO + 8'(cur_pos / 10));
      put(tle_pkg::DEST_ECHO, tle_pkg::CH_ZERO + 8'(cur_pos % 10));
      put(tle_pkg::DEST_ECHO, tle_pkg::CH_C);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    echo_item_t e;
    step_n = 0;
    case (pmode)
      tle_pkg::MODE_READY: begin
        case (b)
          tle_pkg::CH_IAC: pmode = tle_pkg::MODE_IAC;
          tle_pkg::CH_ESC: pmode = tle_pkg::MODE_ESC;
          tle_pkg::CH_ETX: put(tle_pkg::DEST_INTR, tle_pkg::CH_ETX);
          tle_pkg::CH_LF: ;
          tle_pkg::CH_CR: begin
            for (int i = 0; i < line_len; i++) put(tle_pkg::DEST_LINE, line_buf[i]);
            put(tle_pkg::DEST_EOL, 8'h00);
            line_len = 0;
            cur_pos = 0;
            put(tle_pkg::DEST_ECHO, tle_pkg::CH_CR);
            put(tle_pkg::DEST_ECHO, tle_pkg::CH_LF);
          end
          tle_pkg::CH_DEL: begin
            if (line_len > 0 && cur_pos > 0) begin
              cur_pos--;
              for (int i = cur_pos; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
              line_len--;
              if (cur_pos == line_len) begin
                put(tle_pkg::DEST_ECHO, 8'h08); put(tle_pkg::DEST_ECHO, 8'h20);
                put(tle_pkg::DEST_ECHO, 8'h08);
              end else put_redraw();
            end
          end
          default: begin
            if (line_len < tle_pkg::LINE_MAX) begin
              if (cur_pos == line_len) begin
                line_buf[line_len] = b;
                line_len++;
                cur_pos++;
                put(tle_pkg::DEST_ECHO, b);
              end else begin
                for (int i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
                line_buf[cur_pos] = b;
                line_len++;
                cur_pos++;
                put_redraw();
              end
            end
          end
        endcase
      end
      tle_pkg::MODE_IAC: begin
        if (b == tle_pkg::CH_IAC) begin
          if (line_len < tle_pkg::LINE_MAX) begin
            line_buf[line_len] = tle_pkg::CH_IAC;
            line_len++;
          end
          pmode = tle_pkg::MODE_READY;
        end else pmode = tle_pkg::MODE_VERB;
      end
      tle_pkg::MODE_ESC: pmode = (b == tle_pkg::CH_LBRK) ? tle_pkg::MODE_CSI
                                                         : tle_pkg::MODE_READY;
      tle_pkg::MODE_CSI: begin
        if (!(b >= 8'h20 && b <= 8'h2F)) begin
          if (b == tle_pkg::CH_D && cur_pos > 0) begin
            cur_pos--;
            put(tle_pkg::DEST_ECHO, tle_pkg::CH_ESC); put(tle_pkg::DEST_ECHO, tle_pkg::CH_LBRK);
            put(tle_pkg::DEST_ECHO, tle_pkg::CH_D);
          end
          pmode = tle_pkg::MODE_READY;
        end
      end
      default: pmode = tle_pkg::MODE_READY;
    endcase
    if (step_n > 0) begin
      e = expected_q[expected_q.size() - 1];
      e.last = 1'b1;
      expected_q[expected_q.size() - 1] = e;
    end
  endfunction

  // driver: presents queued bytes and output stalls at the falling edge
  always @(negedge clk) begin
    logic nv;
    nv = rx_valid;
    if (!rst) begin
      if (rx_valid && in_taken) begin
        // transfer happened at the last rising edge
        nv = 1'b0;
        tx_gap = $urandom_range(0, 3);
      end
      if (!nv) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_q.size() > 0) begin
          rx_byte <= pending_q.pop_front();
          nv = 1'b1;
        end
      end
      if (out_taken) rs_gap = $urandom_range(0, 3);
      if (rs_gap > 0) begin
        out_stall <= 1'b1;
        rs_gap--;
      end else out_stall <= 1'b0;
    end
    rx_valid <= nv;
  end

  // monitor: rising edge sampling, prediction on each input transfer
  always @(posedge clk) begin
    echo_item_t e;
    in_taken  <= !rst && rx_valid && !rx_stall;
    out_taken <= !rst && out_valid && !out_stall;
    if (rst || (rx_valid && !rx_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst) begin
      if (rx_valid && !rx_stall) predict_byte(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result dest=%0d data=%02h last=%0d", dest, out_data, last);
        end else begin
          e = expected_q.pop_front();
          if (e.dest !== dest || e.data !== out_data || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp dest=%0d data=%02h last=%0d got dest=%0d data=%02h last=%0d",
                       e.dest, e.data, e.last, dest, out_data, last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("[telnet_line_editor_top] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  initial begin
    // directed: specials, extremes, full buffer
    pending_q = '{"a", "b", tle_pkg::CH_ESC, tle_pkg::CH_LBRK, tle_pkg::CH_D, "X",
                  tle_pkg::CH_DEL, tle_pkg::CH_DEL, 8'h0A, tle_pkg::CH_ETX,
                  tle_pkg::CH_IAC, tle_pkg::CH_IAC, tle_pkg::CH_IAC, 8'hFB, 8'h01,
                  tle_pkg::CH_ESC, "x", tle_pkg::CH_ESC, tle_pkg::CH_LBRK,
                  8'h20, 8'h2F, tle_pkg::CH_D, tle_pkg::CH_CR, tle_pkg::CH_DEL,
                  tle_pkg::CH_CR};
    for (int i = 0; i < tle_pkg::LINE_MAX + 1; i++) add_byte(8'h80 + 8'(i));
    add_byte(tle_pkg::CH_IAC); add_byte(tle_pkg::CH_IAC);
    for (int i = 0; i < 3; i++) begin
      add_byte(tle_pkg::CH_ESC); add_byte(tle_pkg::CH_LBRK); add_byte(tle_pkg::CH_D);
    end
    add_byte(tle_pkg::CH_DEL);
    add_byte("q");
    add_byte(tle_pkg::CH_CR);
    // random: mostly edit sequences with random content
    while (pending_q.size() < 108) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_byte(rand_print());
        3: begin
          add_byte(tle_pkg::CH_ESC); add_byte(tle_pkg::CH_LBRK);
          if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(8'h20, 8'h2F)));
          add_byte(($urandom_range(0, 4) != 0) ? tle_pkg::CH_D : 8'($urandom));
        end
        4: add_byte(tle_pkg::CH_DEL);
        5: begin
          add_byte(tle_pkg::CH_IAC);
          add_byte(($urandom_range(0, 1) != 0) ? tle_pkg::CH_IAC
                                               : 8'($urandom_range(8'hF0, 8'hFE)));
          if (pending_q[$] != tle_pkg::CH_IAC) add_byte(8'($urandom));
        end
        6: add_byte(($urandom_range(0, 2) == 0) ? tle_pkg::CH_CR : tle_pkg::CH_ETX);
        default: add_byte(8'($urandom));
      endcase
    end
    add_byte(tle_pkg::CH_CR);
    stim_done = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // end of run
  initial begin
    wait (stim_done);
    @(negedge clk);
    while (rst || pending_q.size() > 0 || rx_valid || expected_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[telnet_line_editor_top] OK");
    end else begin
      $display("[telnet_line_editor_top] ERROR");
    end
    $finish;
  end
endmodule
